FILE: rtl/smf_pkg.sv
// ----------------------------------------------------------------------------
// Sliding median filter package
// Default window length and sample width shared by the filter modules.
// ----------------------------------------------------------------------------
package smf_pkg;

   localparam int DEFAULT_WINDOW_LEN  = 5;
   localparam int DEFAULT_SAMPLE_BITS = 12;

endpackage

FILE: rtl/smf_cell.sv
// ----------------------------------------------------------------------------
// Sliding median filter window cell
// Holds one sample of the window and its rank among the window samples, and
// hands both, with the rank adjusted for the incoming and outgoing sample, to
// the next older cell on every accepted beat.
// ----------------------------------------------------------------------------
module smf_cell #(
   parameter int SAMPLE_BITS = smf_pkg::DEFAULT_SAMPLE_BITS,
   parameter int RANK_BITS   = $clog2(smf_pkg::DEFAULT_WINDOW_LEN),
   parameter int PRIME_RANK  = 0
) (
   input  logic                   clock,
   input  logic                   load,
   input  logic                   prime,
   input  logic [SAMPLE_BITS-1:0] sample,
   input  logic [SAMPLE_BITS-1:0] drop_value,
   input  logic [SAMPLE_BITS-1:0] left_value,
   input  logic [RANK_BITS-1:0]   left_rank,
   output logic [SAMPLE_BITS-1:0] value,
   output logic [RANK_BITS-1:0]   rank,
   output logic [RANK_BITS-1:0]   fwd_rank,
   output logic                   le_sample
);

   logic [SAMPLE_BITS-1:0] value_ff;
   logic [SAMPLE_BITS-1:0] value_in;
   logic [RANK_BITS-1:0]   rank_ff;
   logic [RANK_BITS-1:0]   rank_in;
   logic                   lt_sample;
   logic                   le_drop;

   // Equal samples are ordered by age, the older one first. The new sample is
   // the youngest, and the dropped sample is the oldest of all.
   always_comb begin
      lt_sample = sample < value_ff;
      le_drop   = drop_value <= value_ff;
      le_sample = value_ff <= sample;
      fwd_rank  = rank_ff + RANK_BITS'(lt_sample) - RANK_BITS'(le_drop);
      if (prime) begin
         value_in = sample;
         rank_in  = RANK_BITS'(PRIME_RANK);
      end else begin
         value_in = left_value;
         rank_in  = left_rank;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         value_ff <= value_in;
         rank_ff  <= rank_in;
      end
   end

   assign value = value_ff;
   assign rank  = rank_ff;

endmodule

FILE: rtl/sliding_median_of_five_filter.sv
// ----------------------------------------------------------------------------
// Sliding median-of-five filter
// The median of a sample shows on the result port in the cycle after its beat
// is accepted. Throughput: one sample per cycle unless the result stalls,
// set by the row of window cells, which shift and re-rank the window together.
// Reset clears the primed flag and the result valid; the first sample after
// reset fills every cell of the window.
// ----------------------------------------------------------------------------
module sliding_median_of_five_filter #(
   parameter int WINDOW_LEN  = smf_pkg::DEFAULT_WINDOW_LEN,
   parameter int SAMPLE_BITS = smf_pkg::DEFAULT_SAMPLE_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [SAMPLE_BITS-1:0] req_sample,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [SAMPLE_BITS-1:0] rsp_median
);

   localparam int RANK_BITS = $clog2(WINDOW_LEN);
   localparam int MID_RANK  = WINDOW_LEN / 2;

   logic                   primed_ff;
   logic                   primed_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic                   accept;
   logic [RANK_BITS-1:0]   new_rank;
   logic [SAMPLE_BITS-1:0] median;

   logic [SAMPLE_BITS-1:0] cell_value    [WINDOW_LEN];
   logic [RANK_BITS-1:0]   cell_rank     [WINDOW_LEN];
   logic [RANK_BITS-1:0]   cell_fwd_rank [WINDOW_LEN];
   logic                   cell_le       [WINDOW_LEN];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // The new sample ranks above every remaining sample that is not larger.
   always_comb begin
      new_rank = '0;
      for (int i = 0; i < WINDOW_LEN - 1; i++) begin
         new_rank = new_rank + RANK_BITS'(cell_le[i]);
      end
   end

   genvar k;
   generate
      for (k = 0; k < WINDOW_LEN; k++) begin : g_cell
         if (k == 0) begin : g_head
            smf_cell #(
               .SAMPLE_BITS(SAMPLE_BITS),
               .RANK_BITS  (RANK_BITS),
               .PRIME_RANK (WINDOW_LEN - 1)
            ) u_cell (
               .clock     (clock),
               .load      (accept),
               .prime     (!primed_ff),
               .sample    (req_sample),
               .drop_value(cell_value[WINDOW_LEN-1]),
               .left_value(req_sample),
               .left_rank (new_rank),
               .value     (cell_value[k]),
               .rank      (cell_rank[k]),
               .fwd_rank  (cell_fwd_rank[k]),
               .le_sample (cell_le[k])
            );
         end else begin : g_body
            smf_cell #(
               .SAMPLE_BITS(SAMPLE_BITS),
               .RANK_BITS  (RANK_BITS),
               .PRIME_RANK (WINDOW_LEN - 1 - k)
            ) u_cell (
               .clock     (clock),
               .load      (accept),
               .prime     (!primed_ff),
               .sample    (req_sample),
               .drop_value(cell_value[WINDOW_LEN-1]),
               .left_value(cell_value[k-1]),
               .left_rank (cell_fwd_rank[k-1]),
               .value     (cell_value[k]),
               .rank      (cell_rank[k]),
               .fwd_rank  (cell_fwd_rank[k]),
               .le_sample (cell_le[k])
            );
         end
      end
   endgenerate

   // Exactly one cell holds the middle rank.
   always_comb begin
      median = '0;
      for (int i = 0; i < WINDOW_LEN; i++) begin
         if (cell_rank[i] == RANK_BITS'(MID_RANK)) begin
            median = median | cell_value[i];
         end
      end
   end

   always_comb begin
      primed_in    = primed_ff || accept;
      rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         primed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         primed_ff    <= primed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_median = median;

endmodule
